// ===== src/hpv_pkg.sv =====
`default_nettype none
package hpv_pkg;

  localparam int HEADER_BYTES = 17;
  localparam int POS_W        = 5;

  // header byte positions
  localparam logic [POS_W-1:0] POS_HDR_END    = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_SEQ_FIRST  = 5'd0;
  localparam logic [POS_W-1:0] POS_SEQ_LAST   = 5'd3;
  localparam logic [POS_W-1:0] POS_ACK_FIRST  = 5'd4;
  localparam logic [POS_W-1:0] POS_ACK_LAST   = 5'd7;
  localparam logic [POS_W-1:0] POS_CHECK      = 5'd8;
  localparam logic [POS_W-1:0] POS_WIN_FIRST  = 5'd9;
  localparam logic [POS_W-1:0] POS_WIN_LAST   = 5'd10;
  localparam logic [POS_W-1:0] POS_PORT_FIRST = 5'd11;
  localparam logic [POS_W-1:0] POS_PORT_LAST  = 5'd14;
  localparam logic [POS_W-1:0] POS_FLAGS      = 5'd15;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // everything one input byte produces: optional payload result, optional summary
  typedef struct packed {
    logic        pay_vld;
    logic [7:0]  pay_byte;
    logic        sum_vld;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  check;
    logic [15:0] window;
    logic [15:0] dst_port;
    logic [15:0] origin_port;
    logic [3:0]  flags;
    status_t     status;
    logic [15:0] length;
  } hpv_run_t;

endpackage
`default_nettype wire

// ===== src/hpv_in_if.sv =====
`default_nettype none
interface hpv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_packet;

  modport source (output valid, output byte_in, output end_of_packet, input ready);
  modport sink   (input valid, input byte_in, input end_of_packet, output ready);
endinterface
`default_nettype wire

// ===== src/hpv_out_if.sv =====
`default_nettype none
interface hpv_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] sequence_value;
  logic [31:0] acknowledge_value;
  logic [7:0]  header_check_byte;
  logic [15:0] window_value;
  logic [15:0] destination_port;
  logic [15:0] source_port;
  logic [3:0]  flag_bits;
  logic [1:0]  status;
  logic [15:0] payload_length;
  logic        last_of_run;

  modport source (output valid, output kind, output payload_byte, output sequence_value,
                  output acknowledge_value, output header_check_byte, output window_value,
                  output destination_port, output source_port, output flag_bits,
                  output status, output payload_length, output last_of_run, input ready);
  modport sink   (input valid, input kind, input payload_byte, input sequence_value,
                  input acknowledge_value, input header_check_byte, input window_value,
                  input destination_port, input source_port, input flag_bits,
                  input status, input payload_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/hpv_parser.sv =====
`default_nettype none
module hpv_parser import hpv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hpv_in_if.sink     in_chan,
  input  wire logic  q_full,
  output logic       push,
  output hpv_run_t   push_run
);

  logic             stg_vld_r;
  logic [7:0]       stg_byte_r;
  logic             stg_eop_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      ack_r, ack_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [15:0]      win_r, win_nxt;
  logic [31:0]      ports_r, ports_nxt;
  logic [3:0]       flags_r, flags_nxt;
  logic [15:0]      cnt_r, cnt_nxt;

  logic             is_hdr;
  logic             fire;

  assign in_chan.ready = !stg_vld_r || !q_full;
  assign fire          = stg_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      stg_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      stg_byte_r <= in_chan.byte_in;
      stg_eop_r  <= in_chan.end_of_packet;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    chk_nxt   = chk_r;
    win_nxt   = win_r;
    ports_nxt = ports_r;
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r + stg_byte_r;
    is_hdr    = pos_r < POS_HDR_END;

    if (is_hdr) begin
      pos_nxt = pos_r + 1'b1;
      case (pos_r) inside
        [POS_SEQ_FIRST:POS_SEQ_LAST]:   seq_nxt   = {seq_r[23:0], stg_byte_r};
        [POS_ACK_FIRST:POS_ACK_LAST]:   ack_nxt   = {ack_r[23:0], stg_byte_r};
        POS_CHECK:                      chk_nxt   = stg_byte_r;
        [POS_WIN_FIRST:POS_WIN_LAST]:   win_nxt   = {win_r[7:0], stg_byte_r};
        [POS_PORT_FIRST:POS_PORT_LAST]: ports_nxt = {ports_r[23:0], stg_byte_r};
        POS_FLAGS:                      flags_nxt = stg_byte_r[7:4]; // ACK SYN FIN RST
        default: ;                      // reserved byte, sum only
      endcase
    end else if (cnt_r != '1) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    push_run.pay_vld     = !is_hdr;
    push_run.pay_byte    = stg_byte_r;
    push_run.sum_vld     = stg_eop_r;
    push_run.seq         = seq_nxt;
    push_run.ack         = ack_nxt;
    push_run.check       = chk_nxt;
    push_run.window      = win_nxt;
    push_run.dst_port    = ports_nxt[31:16];
    push_run.origin_port = ports_nxt[15:0];
    push_run.flags       = flags_nxt;
    push_run.length      = cnt_nxt;
    if (sum_nxt != 8'd0) begin
      push_run.status = STATUS_BAD_SUM;
    end else if (pos_nxt < POS_HDR_END) begin
      push_run.status = STATUS_SHORT;
    end else begin
      push_run.status = STATUS_OK;
    end
  end

  // header bytes that do not end the packet produce nothing
  assign push = fire && (push_run.pay_vld || push_run.sum_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      chk_r   <= '0;
      win_r   <= '0;
      ports_r <= '0;
      flags_r <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      if (stg_eop_r) begin
        pos_r   <= '0;
        sum_r   <= '0;
        seq_r   <= '0;
        ack_r   <= '0;
        chk_r   <= '0;
        win_r   <= '0;
        ports_r <= '0;
        flags_r <= '0;
        cnt_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        sum_r   <= sum_nxt;
        seq_r   <= seq_nxt;
        ack_r   <= ack_nxt;
        chk_r   <= chk_nxt;
        win_r   <= win_nxt;
        ports_r <= ports_nxt;
        flags_r <= flags_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/hpv_out_queue.sv =====
`default_nettype none
module hpv_out_queue import hpv_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire hpv_run_t push_run,
  output logic          q_full,
  hpv_out_if.source     out_chan
);

  hpv_run_t   mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       phase_r;   // payload result of head already sent

  hpv_run_t   head;
  logic       pay_phase;
  logic       xfer;
  logic       pop;

  assign q_full    = cnt_r == 2'd2;
  assign head      = mem[rd_ptr_r];
  assign pay_phase = head.pay_vld && !phase_r;

  assign out_chan.valid = cnt_r != 2'd0;
  assign xfer           = out_chan.valid && out_chan.ready;
  assign pop            = xfer && out_chan.last_of_run;

  always_comb begin
    out_chan.kind              = KIND_SUMMARY;
    out_chan.payload_byte      = '0;
    out_chan.sequence_value    = head.seq;
    out_chan.acknowledge_value = head.ack;
    out_chan.header_check_byte = head.check;
    out_chan.window_value      = head.window;
    out_chan.destination_port  = head.dst_port;
    out_chan.source_port       = head.origin_port;
    out_chan.flag_bits         = head.flags;
    out_chan.status            = head.status;
    out_chan.payload_length    = head.length;
    out_chan.last_of_run       = 1'b1;
    if (pay_phase) begin
      out_chan.kind              = KIND_PAYLOAD;
      out_chan.payload_byte      = head.pay_byte;
      out_chan.sequence_value    = '0;
      out_chan.acknowledge_value = '0;
      out_chan.header_check_byte = '0;
      out_chan.window_value      = '0;
      out_chan.destination_port  = '0;
      out_chan.source_port       = '0;
      out_chan.flag_bits         = '0;
      out_chan.status            = STATUS_OK;
      out_chan.payload_length    = '0;
      out_chan.last_of_run       = !head.sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      phase_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
      if (xfer) begin
        phase_r <= !out_chan.last_of_run;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/packet_header_parse_verify.sv =====
`default_nettype none
// Packet header deframer with 8-bit additive checksum check.
// Path: an accepted byte is registered in the input stage, then written into the
//   run queue, from which its results are offered.
// Throughput: one byte per cycle while the run queue is not full; a payload byte
//   that ends a packet yields two results (payload, then summary) in turn.
// Reset: synchronous, active low; clears header state, sum, counters and queue.
module packet_header_parse_verify import hpv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  hpv_in_if.sink    in_chan,
  hpv_out_if.source out_chan
);

  // Stage 1: input register plus header capture / running sum / payload count.
  // Each accepted payload byte or packet-ending byte becomes one run record holding
  // an optional payload result and an optional end-of-packet summary.
  logic     push;
  hpv_run_t push_run;
  logic     q_full;

  hpv_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_run (push_run)
  );

  // Stage 2: two-entry run queue. Decouples the sides so a new byte is taken
  // while a finished result waits; the head run is split into its results.
  hpv_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .q_full   (q_full),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

// Deframer testbench. Bytes go in through the input channel, with random
// gaps. An in-line parser model predicts the payload and summary
// transactions for every accepted byte. A checker process compares each
// output transaction, field by field, with the oldest prediction.
module testbench;
  import hpv_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES   = 16;    // room for stray results after the last prediction
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int MAX_PRINTED    = 100;

  typedef logic [7:0] byte_q_t[$];

  // one predicted output transaction
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  check;
    logic [15:0] window;
    logic [15:0] dst_port;
    logic [15:0] origin_port;
    logic [3:0]  flags;
    status_t     status;
    logic [15:0] length;
    logic        last;
  } deframe_result_t;

  logic clk;
  logic rst_n;

  hpv_in_if  in_ch ();
  hpv_out_if out_ch ();

  packet_header_parse_verify u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model: its own copy of the header registers, sum and counters
  // ---------------------------------------------------------------------------
  logic [4:0]  hdr_pos;
  logic [7:0]  hdr_sum;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_ack;
  logic [7:0]  hdr_check;
  logic [15:0] hdr_window;
  logic [31:0] hdr_ports;   // destination high, source low
  logic [3:0]  hdr_flags;
  logic [15:0] pay_count;

  deframe_result_t awaited_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  int unsigned error_count;
  int unsigned quiet_cycles;
  logic        hold_active;
  int unsigned hold_len;
  event        hold_start;

  task automatic clear_parser_state();
    hdr_pos    = '0;
    hdr_sum    = '0;
    hdr_seq    = '0;
    hdr_ack    = '0;
    hdr_check  = '0;
    hdr_window = '0;
    hdr_ports  = '0;
    hdr_flags  = '0;
    pay_count  = '0;
  endtask

  // Apply one accepted byte; queue the transactions it causes.
  task automatic deframe_byte(input logic [7:0] b, input logic eop);
    deframe_result_t r;
    hdr_sum = hdr_sum + b;  // mod 256 by width
    if (hdr_pos < POS_HDR_END) begin
      if (hdr_pos <= POS_SEQ_LAST) begin
        hdr_seq = {hdr_seq[23:0], b};
      end else if (hdr_pos <= POS_ACK_LAST) begin
        hdr_ack = {hdr_ack[23:0], b};
      end else if (hdr_pos == POS_CHECK) begin
        hdr_check = b;
      end else if (hdr_pos <= POS_WIN_LAST) begin
        hdr_window = {hdr_window[7:0], b};
      end else if (hdr_pos <= POS_PORT_LAST) begin
        hdr_ports = {hdr_ports[23:0], b};
      end else if (hdr_pos == POS_FLAGS) begin
        hdr_flags = b[7:4];  // ACK, SYN, FIN, RST map straight down
      end
      // the reserved byte only feeds the sum
      hdr_pos++;
    end else begin
      if (pay_count != 16'hFFFF) pay_count++;
      r              = '0;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      r.last         = !eop;
      awaited_results.insert(awaited_results.size(), r);
    end
    if (eop) begin
      r             = '0;
      r.kind        = KIND_SUMMARY;
      r.seq         = hdr_seq;
      r.ack         = hdr_ack;
      r.check       = hdr_check;
      r.window      = hdr_window;
      r.dst_port    = hdr_ports[31:16];
      r.origin_port = hdr_ports[15:0];
      r.flags       = hdr_flags;
      // checksum is tested ahead of length
      if (hdr_sum != 8'd0) r.status = STATUS_BAD_SUM;
      else if (hdr_pos < POS_HDR_END) r.status = STATUS_SHORT;
      else r.status = STATUS_OK;
      r.length   = pay_count;
      r.last     = 1'b1;
      awaited_results.insert(awaited_results.size(), r);
      clear_parser_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Error reporting
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Drive one byte; returns right after the edge that accepts it.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.byte_in       <= b;
    in_ch.end_of_packet <= eop;
    do @(posedge clk); while (!in_ch.ready);
    deframe_byte(b, eop);
    items_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Make the byte sum zero by adjusting the checksum byte, or the last byte
  // when the packet is too short to carry one.
  task automatic seal_checksum(ref byte_q_t pkt);
    logic [7:0] total;
    int         idx;
    total = '0;
    foreach (pkt[i]) total = total + pkt[i];
    idx = (pkt.size() > POS_CHECK) ? int'(POS_CHECK) : pkt.size() - 1;
    pkt[idx] = pkt[idx] - total;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_error("output transaction with nothing predicted");
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(out_ch.kind), 32'(want.kind));
        check_field("payload_byte", 32'(out_ch.payload_byte), 32'(want.payload_byte));
        check_field("sequence_value", out_ch.sequence_value, want.seq);
        check_field("acknowledge_value", out_ch.acknowledge_value, want.ack);
        check_field("header_check_byte", 32'(out_ch.header_check_byte),
                    32'(want.check));
        check_field("window_value", 32'(out_ch.window_value), 32'(want.window));
        check_field("destination_port", 32'(out_ch.destination_port),
                    32'(want.dst_port));
        check_field("source_port", 32'(out_ch.source_port), 32'(want.origin_port));
        check_field("flag_bits", 32'(out_ch.flag_bits), 32'(want.flags));
        check_field("status", 32'(out_ch.status), 32'(want.status));
        check_field("payload_length", 32'(out_ch.payload_length), 32'(want.length));
        check_field("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
      end
    end
    // back-pressure: random stalls, or held low through a hold-off
    out_ch.ready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold-off counter, kicked from the back-pressure test.
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_start);
      hold_active = 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Single-byte packets at both byte extremes, then one packet with extreme
  // header values and one payload byte that ends it.
  task automatic test_directed();
    byte_q_t pkt;
    pkt = {8'h00};  // sum is zero but too short
    send_packet(pkt);
    pkt = {8'hFF};  // short and bad sum: sum wins
    send_packet(pkt);
    pkt = {8'hFF, 8'hFF, 8'hFF, 8'hFF,   // sequence
           8'h00, 8'h00, 8'h00, 8'h00,   // acknowledge
           8'h00,                        // checksum, sealed below
           8'hFF, 8'hFF,                 // window
           8'h00, 8'h00,                 // destination port
           8'hFF, 8'hFF,                 // source port
           8'hF0,                        // all four flags set
           8'h5A,                        // reserved
           8'h80};                       // payload, ends the packet
    seal_checksum(pkt);
    send_packet(pkt);
  endtask

  // Mostly sealed packets of random content; some short, some header-only,
  // a few long, and some with the sum broken.
  task automatic test_random_packets(input int unsigned count);
    byte_q_t     pkt;
    int unsigned shape;
    int unsigned len;
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      shape = $urandom_range(99);
      if (shape < 10) len = $urandom_range(1, HEADER_BYTES - 1);
      else if (shape < 18) len = HEADER_BYTES;
      else if (shape < 20) len = HEADER_BYTES + $urandom_range(60, 200);
      else len = HEADER_BYTES + $urandom_range(1, 24);
      pkt.delete();
      repeat (len) pkt.insert(pkt.size(), 8'($urandom));
      seal_checksum(pkt);
      if ($urandom_range(99) < 15)
        pkt[$urandom_range(len - 1)] += 8'($urandom_range(1, 255));
      send_packet(pkt);
    end
  endtask

  // Receiver stops for a long stretch while a packet keeps coming, so the
  // block fills and has to drop the input ready.
  task automatic test_backpressure();
    byte_q_t pkt;
    pkt.delete();
    repeat (HEADER_BYTES + 48) pkt.insert(pkt.size(), 8'($urandom));
    seal_checksum(pkt);
    hold_len = HOLD_CYCLES;
    -> hold_start;
    send_packet(pkt);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.byte_in       = '0;
    in_ch.end_of_packet = 1'b0;
    items_sent          = 0;
    error_count         = 0;
    hold_len            = 0;
    send_idle_pct       = 7;
    recv_idle_pct       = 82;
    clear_parser_state();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender busy, receiver mostly stalled
    test_directed();
    test_random_packets(470);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 82;
    recv_idle_pct = 7;
    test_random_packets(470);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_packets(400);

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived",
                           awaited_results.size()));

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/hpv_pkg.sv
src/hpv_in_if.sv
src/hpv_out_if.sv
src/hpv_parser.sv
src/hpv_out_queue.sv
src/packet_header_parse_verify.sv
tb/sv/testbench.sv
